// ----- hdl/fcd_pkg.sv -----
package fcd_pkg;

  localparam int TS_W       = 64;
  localparam int CLS_W      = 4;
  localparam int LEN_W      = 16;
  localparam int PKT_W      = 32;
  localparam int BYTE_W     = 48;
  localparam int NS_W       = 40;
  localparam int MASK_W     = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 16;

  localparam int NUM_CLASSES_DEF    = 9;
  localparam int WINDOW_SECONDS_DEF = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_NS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_NS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PKT_LIMIT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_LIMIT  = 2'd3;

  localparam logic [NS_W-1:0]   WINDOW_NS_RST  = 40'd2000000000;
  localparam logic [NS_W-1:0]   HOLD_NS_RST    = 40'd6000000000;
  localparam logic [PKT_W-1:0]  PKT_LIMIT_RST  = 32'd400;
  localparam logic [BYTE_W-1:0] BYTE_LIMIT_RST = 48'd200000;

  typedef struct packed {
    logic [TS_W-1:0]   stamp;
    logic [BYTE_W-1:0] bytes;
    logic [PKT_W-1:0]  packets;
  } class_entry_t;

  typedef struct packed {
    logic flood;
    logic release_ok;
  } judge_t;

endpackage

// ----- hdl/per_class_flood_detector_unit.sv -----
// per-class flood detector
// in channel: one beat per packet event; in_tdata holds timestamp, class and
// length, in_tuser the header error flag. out channel: one beat per event with
// the drop decision and the mask of currently blocked classes. cfg channel
// writes window_ns, hold_ns, packet and byte rate limits; always ready.
// per-class counters and flood stamps live in a small memory with a registered
// read; an event is a read-modify-write of its class entry. an accepted event
// passes through S_UPD, skipped for an event that only opens the window, and,
// when it closes the window, through S_WALK over all classes, one memory read
// and write per class, to S_DONE, which loads the result into the output
// register. a new event is taken only in S_IDLE, once the last one is done.
// the output register holds a finished result while the next event is
// accepted; if the receiver stalls, the block waits in S_DONE until the
// register frees and accepts no event meanwhile.
// synchronous reset clears the window and the block bits, all counters and
// stamps (via per-entry valid bits) and restores the register defaults.
module per_class_flood_detector_unit #(
  parameter int NUM_CLASSES    = fcd_pkg::NUM_CLASSES_DEF,
  parameter int WINDOW_SECONDS = fcd_pkg::WINDOW_SECONDS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [63:0] timestamp, [67:64] traffic_class, [83:68] packet_length, pad
  input  logic [fcd_pkg::IN_TDATA_W-1:0]      in_tdata,
  // [0] header_error
  input  logic [0:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] drop, [9:1] blocked_mask, pad
  output logic [fcd_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fcd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fcd_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int AW = $clog2(NUM_CLASSES);
  localparam logic [AW-1:0] LAST_CLASS = AW'(NUM_CLASSES - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_UPD  = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;

  logic [fcd_pkg::NS_W-1:0]   window_ns_r;
  logic [fcd_pkg::NS_W-1:0]   hold_ns_r;
  logic [fcd_pkg::PKT_W-1:0]  pkt_limit_r;
  logic [fcd_pkg::BYTE_W-1:0] byte_limit_r;

  logic [fcd_pkg::TS_W-1:0]   win_start_r;
  logic [fcd_pkg::TS_W-1:0]   ts_r;
  logic [fcd_pkg::CLS_W-1:0]  cls_r;
  logic [fcd_pkg::LEN_W-1:0]  len_r;
  logic                       herr_r;
  logic                       first_r;
  logic                       expired_r;
  logic [AW-1:0]              walk_idx_r;
  logic [NUM_CLASSES-1:0]     blocked_r;
  logic                       out_valid_r;
  logic                       drop_r;
  logic [fcd_pkg::MASK_W-1:0] mask_r;

  logic [fcd_pkg::TS_W-1:0]   in_ts;
  logic [fcd_pkg::CLS_W-1:0]  in_cls;
  logic                       in_fire;
  logic                       in_cls_ok;
  logic                       cls_ok;
  logic                       out_free;

  logic [AW-1:0]              rd_addr;
  fcd_pkg::class_entry_t      rd_data;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  fcd_pkg::class_entry_t      wr_data;
  fcd_pkg::judge_t            verdict;

  logic [fcd_pkg::BYTE_W:0]   byte_sum;
  logic [fcd_pkg::MASK_W+NUM_CLASSES-1:0] blocked_ext;

  assign in_ts     = in_tdata[fcd_pkg::TS_W-1:0];
  assign in_cls    = in_tdata[fcd_pkg::TS_W +: fcd_pkg::CLS_W];
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_cls_ok = ({1'b0, in_cls} < (fcd_pkg::CLS_W + 1)'(NUM_CLASSES));
  assign cls_ok    = ({1'b0, cls_r} < (fcd_pkg::CLS_W + 1)'(NUM_CLASSES));
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  assign blocked_ext = {{fcd_pkg::MASK_W{1'b0}}, blocked_r};

  fcd_class_mem #(
    .NUM_CLASSES (NUM_CLASSES),
    .AW          (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  fcd_judge #(
    .WINDOW_SECONDS (WINDOW_SECONDS)
  ) u_judge (
    .clk        (clk),
    .hold_ns    (hold_ns_r),
    .pkt_limit  (pkt_limit_r),
    .byte_limit (byte_limit_r),
    .now        (ts_r),
    .entry      (rd_data),
    .verdict    (verdict)
  );

  always_comb begin
    state_nxt = state_r;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = cls_r[AW-1:0];
    wr_data   = rd_data;
    byte_sum  = {1'b0, rd_data.bytes} + (fcd_pkg::BYTE_W + 1)'(len_r);
    unique case (state_r)
      S_IDLE: begin
        rd_addr = in_cls_ok ? in_cls[AW-1:0] : '0;
        if (in_fire) begin
          state_nxt = (win_start_r == '0) ? S_DONE : S_UPD;
        end
      end
      S_UPD: begin
        wr_en = cls_ok;
        if (rd_data.packets != '1) begin
          wr_data.packets = rd_data.packets + 1'b1;
        end
        wr_data.bytes = byte_sum[fcd_pkg::BYTE_W] ? '1 : byte_sum[fcd_pkg::BYTE_W-1:0];
        state_nxt = expired_r ? S_WALK : S_DONE;
      end
      S_WALK: begin
        wr_en           = 1'b1;
        wr_addr         = walk_idx_r;
        wr_data.packets = '0;
        wr_data.bytes   = '0;
        if (verdict.flood) begin
          wr_data.stamp = ts_r;
        end
        if (walk_idx_r == LAST_CLASS) begin
          state_nxt = S_DONE;
        end else begin
          rd_addr = walk_idx_r + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      window_ns_r  <= fcd_pkg::WINDOW_NS_RST;
      hold_ns_r    <= fcd_pkg::HOLD_NS_RST;
      pkt_limit_r  <= fcd_pkg::PKT_LIMIT_RST;
      byte_limit_r <= fcd_pkg::BYTE_LIMIT_RST;
      win_start_r  <= '0;
      blocked_r    <= '0;
      out_valid_r  <= 1'b0;
      walk_idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          fcd_pkg::REG_WINDOW_NS:  window_ns_r  <= cfg_data[fcd_pkg::NS_W-1:0];
          fcd_pkg::REG_HOLD_NS:    hold_ns_r    <= cfg_data[fcd_pkg::NS_W-1:0];
          fcd_pkg::REG_PKT_LIMIT:  pkt_limit_r  <= cfg_data[fcd_pkg::PKT_W-1:0];
          fcd_pkg::REG_BYTE_LIMIT: byte_limit_r <= cfg_data[fcd_pkg::BYTE_W-1:0];
          default: ;
        endcase
      end
      if (in_fire && (win_start_r == '0)) begin
        win_start_r <= in_ts;
      end
      if ((state_r == S_UPD) && expired_r) begin
        win_start_r <= ts_r;
        walk_idx_r  <= '0;
      end
      if (state_r == S_WALK) begin
        walk_idx_r <= walk_idx_r + 1'b1;
        if (verdict.flood) begin
          blocked_r[walk_idx_r] <= 1'b1;
        end else if (verdict.release_ok) begin
          blocked_r[walk_idx_r] <= 1'b0;
        end
      end
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ts_r      <= in_ts;
      cls_r     <= in_cls;
      len_r     <= in_tdata[fcd_pkg::TS_W + fcd_pkg::CLS_W +: fcd_pkg::LEN_W];
      herr_r    <= in_tuser[0];
      first_r   <= (win_start_r == '0);
      expired_r <= ((in_ts - win_start_r) > fcd_pkg::TS_W'(window_ns_r));
    end
    if ((state_r == S_DONE) && out_free) begin
      drop_r <= !first_r && (herr_r || (cls_ok && blocked_r[cls_r[AW-1:0]]));
      mask_r <= blocked_ext[fcd_pkg::MASK_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(fcd_pkg::OUT_TDATA_W - fcd_pkg::MASK_W - 1){1'b0}}, mask_r, drop_r};

endmodule

// ----- hdl/fcd_class_mem.sv -----
module fcd_class_mem #(
  parameter int NUM_CLASSES = fcd_pkg::NUM_CLASSES_DEF,
  parameter int AW          = $clog2(NUM_CLASSES)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [AW-1:0]        rd_addr,
  output fcd_pkg::class_entry_t rd_data,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  fcd_pkg::class_entry_t wr_data
);

  fcd_pkg::class_entry_t mem [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] valid_r;
  fcd_pkg::class_entry_t  rd_data_r;
  logic                   rd_hit_r;
  logic                   fwd;

  assign fwd = wr_en && (wr_addr == rd_addr);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= fwd ? wr_data : mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      rd_hit_r <= fwd || valid_r[rd_addr];
    end
  end

  // entries never written read as zero
  assign rd_data = rd_hit_r ? rd_data_r : '0;

endmodule

// ----- hdl/fcd_judge.sv -----
module fcd_judge #(
  parameter int WINDOW_SECONDS = fcd_pkg::WINDOW_SECONDS_DEF
) (
  input  logic                          clk,
  input  logic [fcd_pkg::NS_W-1:0]      hold_ns,
  input  logic [fcd_pkg::PKT_W-1:0]     pkt_limit,
  input  logic [fcd_pkg::BYTE_W-1:0]    byte_limit,
  input  logic [fcd_pkg::TS_W-1:0]      now,
  input  fcd_pkg::class_entry_t         entry,
  output fcd_pkg::judge_t               verdict
);

  localparam int WS_W = $clog2(WINDOW_SECONDS + 1);
  localparam int PT_W = fcd_pkg::PKT_W + 1 + WS_W;
  localparam int BT_W = fcd_pkg::BYTE_W + 1 + WS_W;
  localparam logic [WS_W-1:0] WS = WS_W'(WINDOW_SECONDS);

  // count / W > limit  <=>  count >= (limit + 1) * W
  logic [PT_W-1:0] pkt_thr_r;
  logic [BT_W-1:0] byte_thr_r;
  logic [fcd_pkg::TS_W-1:0] since;

  always_ff @(posedge clk) begin
    pkt_thr_r  <= PT_W'({1'b0, pkt_limit} + 1'b1) * PT_W'(WS);
    byte_thr_r <= BT_W'({1'b0, byte_limit} + 1'b1) * BT_W'(WS);
  end

  assign since = now - entry.stamp;

  always_comb begin
    verdict.flood = (PT_W'(entry.packets) >= pkt_thr_r) ||
                    (BT_W'(entry.bytes) >= byte_thr_r);
    verdict.release_ok = (entry.stamp == '0) ||
                         (since > fcd_pkg::TS_W'(hold_ns));
  end

endmodule

// ----- verif/flood_checker.sv -----
`timescale 1ns / 1ps

module flood_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  input  logic [fcd_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic [0:0]                         in_tuser,
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic [fcd_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [fcd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fcd_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                 fail_count,
  output int                                 pending
);
  import fcd_pkg::*;

  localparam int NCLS = NUM_CLASSES_DEF;
  localparam logic [63:0] WSEC = 64'(WINDOW_SECONDS_DEF);

  typedef struct packed {
    logic              drop;
    logic [MASK_W-1:0] mask;
  } verdict_t;

  verdict_t pending_verdicts[$];

  logic [NS_W-1:0]   window_len;
  logic [NS_W-1:0]   hold_len;
  logic [PKT_W-1:0]  pkt_lim;
  logic [BYTE_W-1:0] byte_lim;

  logic [TS_W-1:0]   win_start;
  logic [PKT_W-1:0]  pkt_cnt[NCLS];
  logic [BYTE_W-1:0] byte_cnt[NCLS];
  logic              blocked[NCLS];
  logic [TS_W-1:0]   flood_stamp[NCLS];

  task automatic clear_state();
    window_len = WINDOW_NS_RST;
    hold_len = HOLD_NS_RST;
    pkt_lim = PKT_LIMIT_RST;
    byte_lim = BYTE_LIMIT_RST;
    win_start = '0;
    for (int c = 0; c < NCLS; c++) begin
      pkt_cnt[c] = '0;
      byte_cnt[c] = '0;
      blocked[c] = 1'b0;
      flood_stamp[c] = '0;
    end
  endtask

  // window close: judge every class, then clear its counters
  task automatic rejudge_classes(input logic [TS_W-1:0] now);
    logic [63:0] pps;
    logic [63:0] bps;
    for (int c = 0; c < NCLS; c++) begin
      pps = 64'(pkt_cnt[c]) / WSEC;
      bps = 64'(byte_cnt[c]) / WSEC;
      if (pps > 64'(pkt_lim) || bps > 64'(byte_lim)) begin
        flood_stamp[c] = now;
        blocked[c] = 1'b1;
      end else if (flood_stamp[c] == '0 || (now - flood_stamp[c]) > 64'(hold_len)) begin
        blocked[c] = 1'b0;
      end
      pkt_cnt[c] = '0;
      byte_cnt[c] = '0;
    end
  endtask

  task automatic predict_verdict(input logic [TS_W-1:0] ts, input logic [CLS_W-1:0] cls,
                                 input logic [LEN_W-1:0] len, input logic herr);
    verdict_t v;
    logic [BYTE_W-1:0] room;
    logic [TS_W-1:0] elapsed;
    v.drop = 1'b0;
    if (win_start == '0) begin
      win_start = ts;
    end else begin
      if (cls < NCLS) begin
        if (pkt_cnt[cls] != '1) pkt_cnt[cls] = pkt_cnt[cls] + 1'b1;
        room = '1 - byte_cnt[cls];
        if (BYTE_W'(len) > room) begin
          byte_cnt[cls] = '1;
        end else begin
          byte_cnt[cls] = byte_cnt[cls] + BYTE_W'(len);
        end
      end
      elapsed = ts - win_start;
      if (elapsed > 64'(window_len)) begin
        win_start = ts;
        rejudge_classes(ts);
      end
      if (herr) begin
        v.drop = 1'b1;
      end else if (cls < NCLS) begin
        v.drop = blocked[cls];
      end
    end
    v.mask = '0;
    for (int c = 0; c < NCLS; c++) v.mask[c] = blocked[c];
    pending_verdicts.push_back(v);
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      clear_state();
      pending_verdicts.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WINDOW_NS:  window_len = cfg_data[NS_W-1:0];
          REG_HOLD_NS:    hold_len = cfg_data[NS_W-1:0];
          REG_PKT_LIMIT:  pkt_lim = cfg_data[PKT_W-1:0];
          REG_BYTE_LIMIT: byte_lim = cfg_data[BYTE_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (pending_verdicts.size() == 0) begin
          $error("result beat with no event waiting: out_tdata %h", out_tdata);
          fail_count++;
        end else begin
          want = pending_verdicts.pop_front();
          if (out_tdata[0] !== want.drop) begin
            $error("drop mismatch: expected %0d, actual %0d", want.drop, out_tdata[0]);
            fail_count++;
          end
          if (out_tdata[MASK_W:1] !== want.mask) begin
            $error("blocked_mask mismatch: expected %h, actual %h", want.mask,
                   out_tdata[MASK_W:1]);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predict_verdict(in_tdata[63:0], in_tdata[67:64], in_tdata[83:68], in_tuser[0]);
      end
    end
    pending = pending_verdicts.size();
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import fcd_pkg::*;

  localparam int LIMIT = 400000;
  localparam int SETTLE = NUM_CLASSES_DEF + 8;
  localparam logic [TS_W-1:0] TS_MAX = '1;
  localparam logic [NS_W-1:0] NS_MAX = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int pending;
  int in_idle_pct = 15;
  int out_idle_pct = 48;
  int cycle_cnt = 0;

  per_class_flood_detector_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  flood_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("per_class_flood_detector_unit regression: fail");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_event(input logic [TS_W-1:0] ts, input logic [CLS_W-1:0] cls,
                            input logic [LEN_W-1:0] len, input logic herr);
    logic rdy;
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, len, cls, ts};
    in_tuser <= herr;
    do begin
      @(negedge clk);
      rdy = in_tready;
      @(posedge clk);
    end while (!rdy);
  endtask

  // hold the sender until every outstanding verdict is back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    logic rdy;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // unused upper data bits get random junk
  task automatic set_regs(input logic [NS_W-1:0] win, input logic [NS_W-1:0] hold,
                          input logic [PKT_W-1:0] pkt_lim, input logic [BYTE_W-1:0] byte_lim);
    cfg_write(REG_WINDOW_NS, {8'($urandom), win});
    cfg_write(REG_HOLD_NS, {8'($urandom), hold});
    cfg_write(REG_PKT_LIMIT, {16'($urandom), pkt_lim});
    cfg_write(REG_BYTE_LIMIT, byte_lim);
  endtask

  initial begin
    logic [TS_W-1:0] ts;
    logic [TS_W-1:0] step_max;
    logic [NS_W-1:0] win;
    logic [NS_W-1:0] hold;
    logic [PKT_W-1:0] pkt_lim;
    logic [BYTE_W-1:0] byte_lim;
    logic [CLS_W-1:0] cls;
    logic [CLS_W-1:0] hot;
    logic [LEN_W-1:0] len;
    int r;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default registers: unstarted window, header errors, stray classes
    send_event(64'd0, 4'd3, 16'd100, 1'b0);
    send_event(64'd0, 4'd8, 16'hFFFF, 1'b1);
    send_event(64'd100, 4'd0, 16'd10, 1'b1);
    send_event(64'd200, 4'd0, 16'hFFFF, 1'b1);
    send_event(64'd300, 4'd15, 16'd0, 1'b0);
    send_event(64'd400, 4'd9, 16'hFFFF, 1'b1);
    send_event(64'd2000000100, 4'd1, 16'd1, 1'b0);
    send_event(64'd2000000101, 4'd8, 16'd2, 1'b0);

    // zero limits: wrap to time zero, zero stamp, time going backwards
    drain();
    set_regs(40'd10, 40'd0, 32'd0, 48'd0);
    send_event(TS_MAX - 64'd49, 4'd2, 16'd1000, 1'b0);
    send_event(TS_MAX - 64'd44, 4'd2, 16'd3, 1'b0);
    send_event(64'd0, 4'd5, 16'd100, 1'b0);
    send_event(64'd5, 4'd5, 16'd0, 1'b1);
    send_event(64'd100, 4'd5, 16'd0, 1'b0);
    send_event(64'd50, 4'd6, 16'd4, 1'b0);
    send_event(64'd60, 4'd6, 16'd1, 1'b1);

    // widest window and hold, limits at maximum
    drain();
    set_regs(NS_MAX, NS_MAX, '1, '1);
    send_event(64'd61, 4'd7, 16'hFFFF, 1'b0);
    send_event(64'd50 + 64'(NS_MAX), 4'd4, 16'd7, 1'b0);
    send_event(64'd51 + 64'(NS_MAX), 4'd6, 16'd7, 1'b0);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      if (ph < 2) begin
        in_idle_pct <= 15;
        out_idle_pct <= 48;
      end else if (ph < 4) begin
        in_idle_pct <= 48;
        out_idle_pct <= 15;
      end else begin
        in_idle_pct <= 0;
        out_idle_pct <= 0;
      end
      win = NS_W'($urandom_range(20, 3000));
      hold = NS_W'($urandom_range(0, 6000));
      pkt_lim = PKT_W'($urandom_range(0, 3));
      byte_lim = BYTE_W'($urandom_range(0, 120000));
      step_max = 64'(win) / 64'($urandom_range(1, 6));
      if (ph == 0) begin
        win = 40'd1;
        hold = 40'd0;
        step_max = 64'd2;
      end else if (ph == 3) begin
        hold = NS_MAX;
      end else if (ph == 5) begin
        win = NS_MAX;
        hold = NS_MAX;
        pkt_lim = '1;
        byte_lim = '1;
        step_max = 64'd1 << 42;
      end
      set_regs(win, hold, pkt_lim, byte_lim);
      hot = CLS_W'($urandom_range(0, 8));
      ts = (ph % 2) ? rand64() : 64'($urandom_range(1, 1000));
      for (int n = 0; n < 180; n++) begin
        if (n == 90) drain();
        r = $urandom_range(99);
        if (r < 4) ts = rand64();
        else ts = ts + (rand64() % (step_max + 64'd1));
        r = $urandom_range(99);
        if (r < 50) cls = hot;
        else if (r < 85) cls = CLS_W'($urandom_range(0, 8));
        else cls = CLS_W'($urandom_range(0, 15));
        len = ($urandom_range(1) == 0) ? LEN_W'($urandom) : LEN_W'($urandom_range(0, 200));
        send_event(ts, cls, len, $urandom_range(99) < 12);
      end
    end

    drain();
    @(negedge clk);
    if (fail_count == 0) begin
      $display("per_class_flood_detector_unit regression: pass");
    end else begin
      $display("per_class_flood_detector_unit regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/fcd_pkg.sv
hdl/fcd_class_mem.sv
hdl/fcd_judge.sv
hdl/per_class_flood_detector_unit.sv
verif/flood_checker.sv
verif/tb.sv
